// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masked
`define AHE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ahe check failed");

// next-cycle implication, reset masked
`define AHE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ahe check failed");

`endif

// ===== hdl/ahe_pkg.sv =====
`default_nettype none

package ahe_pkg;

   localparam int PixelW = 8;
   localparam int SumW   = 14;
   localparam int CountW = 7;
   localparam int HashW  = 64;
   localparam int BitIdxW = 6;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_PASS,
      ST_EMIT
   } ahe_state_type;

   typedef struct packed {
      logic load;
      logic pass_init;
      logic pass_run;
      logic emit;
   } ahe_cmd_type;

   typedef struct packed {
      logic set_close;
      logic pass_done;
   } ahe_status_type;

endpackage

`default_nettype wire

// ===== hdl/ahe_req_if.sv =====
`default_nettype none

interface ahe_req_if import ahe_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PixelW-1:0] pixel_value;
   logic              last_item;

   modport source (output valid, output pixel_value, output last_item, input ready);
   modport sink   (input valid, input pixel_value, input last_item, output ready);
endinterface

`default_nettype wire

// ===== hdl/ahe_rsp_if.sv =====
`default_nettype none

interface ahe_rsp_if import ahe_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HashW-1:0]  hash_bits;
   logic [CountW-1:0] pixels_used;

   modport source (output valid, output hash_bits, output pixels_used, input ready);
   modport sink   (input valid, input hash_bits, input pixels_used, output ready);
endinterface

`default_nettype wire

// ===== hdl/average_hash_engine_core.sv =====
`default_nettype none

// Average hash over one set of 8-bit grayscale pixels, one pixel per request.
// A set closes at the request marked last_item or at the MAX_PIXELS-th pixel;
// the block then returns a 64-bit hash (bit 63 for the first pixel, set where
// pixel * count < sum, i.e. strictly below the mean; unused low bits zero) and
// the pixel count. Pixels load into an on-chip store at one per cycle while
// the block is in its load state. After the closing pixel a compare pass reads
// the store back, one pixel per cycle through a single 8x7 multiplier. New
// pixels are not taken during the compare pass or while a response is being
// emitted; they are taken while a finished response waits.

module average_hash_engine_core
   import ahe_pkg::*;
#(
   parameter int MAX_PIXELS = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   ahe_req_if.sink   req_chan,
   ahe_rsp_if.source rsp_chan
);

   ahe_cmd_type    cmd;
   ahe_status_type status;

   ahe_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ahe_datapath #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .pixel_value (req_chan.pixel_value),
      .last_item   (req_chan.last_item),
      .hash_bits   (rsp_chan.hash_bits),
      .pixels_used (rsp_chan.pixels_used)
   );

endmodule

`default_nettype wire

// ===== hdl/ahe_datapath.sv =====
`default_nettype none

`include "assert_macros.svh"

module ahe_datapath
   import ahe_pkg::*;
#(
   parameter int MAX_PIXELS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ahe_cmd_type       cmd,
   output ahe_status_type         status,
   input  wire logic [PixelW-1:0] pixel_value,
   input  wire logic              last_item,
   output logic [HashW-1:0]       hash_bits,
   output logic [CountW-1:0]      pixels_used
);

   localparam int AddrW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

   logic [PixelW-1:0]  mem_ff [MAX_PIXELS];
   logic [PixelW-1:0]  rd_data_ff;
   logic [CountW-1:0]  count_ff, count_in, count_inc;
   logic [SumW-1:0]    sum_ff, sum_in;
   logic [CountW-1:0]  pass_ff, pass_in;
   logic [HashW-1:0]   hash_ff, hash_in;
   logic [HashW-1:0]   out_hash_ff;
   logic [CountW-1:0]  out_used_ff;
   logic [BitIdxW-1:0] cmp_idx;
   logic [SumW:0]      product;
   logic               below;

   assign count_inc = count_ff + CountW'(1);
   assign status.set_close = last_item || (count_inc >= CountW'(MAX_PIXELS));
   assign status.pass_done = (pass_ff == count_ff);

   assign cmp_idx = BitIdxW'(pass_ff - CountW'(1));
   assign product = (SumW+1)'(rd_data_ff) * (SumW+1)'(count_ff);
   assign below   = product < {1'b0, sum_ff};

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      if (cmd.emit) begin
         count_in = '0;
         sum_in   = '0;
      end else if (cmd.load) begin
         count_in = count_inc;
         sum_in   = sum_ff + SumW'(pixel_value);
      end
   end

   always_comb begin
      pass_in = pass_ff;
      hash_in = hash_ff;
      if (cmd.pass_init) begin
         pass_in = '0;
         hash_in = '0;
      end else if (cmd.pass_run) begin
         if (!status.pass_done) begin
            pass_in = pass_ff + CountW'(1);
         end
         if (pass_ff != '0) begin
            hash_in[~cmp_idx] = below;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         pass_ff  <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         pass_ff  <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mem_ff[count_ff[AddrW-1:0]] <= pixel_value;
      end
      if (cmd.pass_run && !status.pass_done) begin
         rd_data_ff <= mem_ff[pass_ff[AddrW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
      if (cmd.emit) begin
         out_hash_ff <= hash_ff;
         out_used_ff <= count_ff;
      end
   end

   assign hash_bits   = out_hash_ff;
   assign pixels_used = out_used_ff;

   `AHE_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CountW'(MAX_PIXELS))
   `AHE_ASSERT_IMPLY(a_emit_nonempty, clock, reset, cmd.emit, count_ff != '0)

endmodule

`default_nettype wire

// ===== hdl/ahe_controller.sv =====
`default_nettype none

`include "assert_macros.svh"

module ahe_controller
   import ahe_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   input  wire ahe_status_type status,
   output ahe_cmd_type         cmd
);

   ahe_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_LOAD: begin
            req_ready     = 1'b1;
            cmd.pass_init = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.set_close) begin
                  state_in = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            cmd.pass_run = 1'b1;
            if (status.pass_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `AHE_ASSERT_NEXT(a_close_to_pass, clock, reset, cmd.load && status.set_close, state_ff == ST_PASS)
   `AHE_ASSERT_NEXT(a_emit_valid, clock, reset, cmd.emit, rsp_valid_ff && state_ff == ST_LOAD)

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;
   import ahe_pkg::*;

   localparam int MaxPix     = 64;
   localparam int LongHold   = 400;
   localparam int WatchLimit = 3000;
   localparam int TailWait   = 200;

   typedef struct {
      logic [HashW-1:0]  hash_bits;
      logic [CountW-1:0] pixels_used;
   } hash_result_type;

   typedef enum int {PIX_RANDOM, PIX_EXTREME, PIX_PAIR, PIX_FLAT} pix_style_type;

   class hash_scoreboard;
      logic [PixelW-1:0] pixels [MaxPix];
      logic [SumW-1:0]   sum_acc;
      logic [CountW-1:0] pix_cnt;
      hash_result_type   hashes_due [$];
      int                errors;

      function new();
         sum_acc = '0;
         pix_cnt = '0;
         errors  = 0;
      endfunction

      task report(input string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      function int pending();
         return hashes_due.size();
      endfunction

      // mirrors the set accumulation; closes at the mark or at a full store
      function void note_pixel(input logic [PixelW-1:0] pix, input logic mark);
         hash_result_type res;
         int i;
         if (pix_cnt < MaxPix) pixels[pix_cnt[BitIdxW-1:0]] = pix;
         sum_acc = sum_acc + SumW'(pix);
         pix_cnt = pix_cnt + 1'b1;
         if (mark || pix_cnt >= MaxPix) begin
            res.hash_bits = '0;
            for (i = 0; i < int'(pix_cnt); i++) begin
               if (int'(pixels[i]) * int'(pix_cnt) < int'(sum_acc))
                  res.hash_bits[HashW-1-i] = 1'b1;
            end
            res.pixels_used = pix_cnt;
            hashes_due.push_back(res);
            sum_acc = '0;
            pix_cnt = '0;
         end
      endfunction

      task check_hash(input logic [HashW-1:0] hash, input logic [CountW-1:0] used);
         hash_result_type want;
         if (hashes_due.size() == 0) begin
            report($sformatf("unexpected response hash %h count %0d", hash, used));
         end else begin
            want = hashes_due.pop_front();
            if (hash !== want.hash_bits)
               report($sformatf("hash %h, expected %h", hash, want.hash_bits));
            if (used !== want.pixels_used)
               report($sformatf("pixels_used %0d, expected %0d", used, want.pixels_used));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   ahe_req_if req_chan ();
   ahe_rsp_if rsp_chan ();

   average_hash_engine_core #(.MAX_PIXELS(MaxPix)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   hash_scoreboard sb;
   bit gaps_on;
   bit rsp_hold_req;
   int rsp_hold_left;
   int items_sent;
   int quiet_cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // called at a rising edge; returns at the edge where the request is taken
   task automatic send_pixel(input logic [PixelW-1:0] pix, input logic mark);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.pixel_value <= pix;
      req_chan.last_item   <= mark;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      items_sent++;
   endtask

   task automatic send_set(input int len, input pix_style_type style);
      logic [PixelW-1:0] base;
      logic [PixelW-1:0] pix;
      logic mark;
      int k;
      base = PixelW'($urandom_range(0, 255));
      for (k = 0; k < len; k++) begin
         case (style)
            PIX_RANDOM:  pix = PixelW'($urandom_range(0, 255));
            PIX_EXTREME: pix = $urandom_range(0, 1) ? 8'hff : 8'h00;
            PIX_PAIR:    pix = base + PixelW'($urandom_range(0, 1));
            default:     pix = base;
         endcase
         if (k != len - 1) mark = 1'b0;
         else if (len == MaxPix) mark = 1'($urandom_range(0, 1));
         else mark = 1'b1;
         send_pixel(pix, mark);
      end
   endtask

   // mostly well-formed sets; some runs with stray marks or overlong sets
   task automatic random_set();
      int r;
      int n;
      int k;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         n = $urandom_range(1, 80);
         for (k = 0; k < n; k++)
            send_pixel(PixelW'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else begin
         if (r < 30) n = MaxPix;
         else if (r < 75) n = $urandom_range(1, 8);
         else n = $urandom_range(9, MaxPix - 1);
         send_set(n, pix_style_type'($urandom_range(0, 3)));
      end
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            sb.note_pixel(req_chan.pixel_value, req_chan.last_item);
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_hash(rsp_chan.hash_bits, rsp_chan.pixels_used);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchLimit) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      bit hold_taken;
      hold_taken = 1'b0;
      rsp_chan.ready <= 1'b0;
      rsp_hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req && !hold_taken) begin
            rsp_hold_left = LongHold;
            hold_taken    = 1'b1;
         end else if (rsp_hold_left == 0 && gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_hold_left = pick_gap();
         end
         if (rsp_hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      int k;
      sb = new();
      gaps_on = 1'b1;
      rsp_hold_req = 1'b0;
      items_sent = 0;
      reset <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.pixel_value <= '0;
      req_chan.last_item   <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // single pixel sets
      send_pixel(8'h00, 1'b1);
      send_pixel(8'hff, 1'b1);
      // uniform set
      for (k = 0; k < 3; k++) send_pixel(8'h80, k == 2);
      // alternating extremes
      for (k = 0; k < 4; k++) send_pixel(k[0] ? 8'hff : 8'h00, k == 3);
      send_pixel(8'd10, 1'b0);
      send_pixel(8'd10, 1'b0);
      send_pixel(8'd10, 1'b0);
      send_pixel(8'd200, 1'b1);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd254, 1'b0);
      send_pixel(8'd1, 1'b1);

      while (items_sent < 800) random_set();

      // hold the response side while requests keep coming
      gaps_on = 1'b0;
      rsp_hold_req = 1'b1;
      for (k = 0; k < 3; k++) send_set(MaxPix, pix_style_type'($urandom_range(0, 3)));
      send_set($urandom_range(1, 8), PIX_RANDOM);
      wait_drained();

      while (items_sent < 1150) random_set();
      gaps_on = 1'b1;
      while (items_sent < 1950) random_set();
      send_pixel(PixelW'($urandom_range(0, 255)), 1'b1);
      wait_drained();
      repeat (TailWait) @(posedge clock);

      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
